// ----- hdl/sfrd_pkg.sv -----
// sfrd_pkg: shared constants, codes and controller/datapath structs
// for the sbus frame resync decoder; no dependencies
`default_nettype none

package sfrd_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 25;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int FLAG_POS    = FRAME_BYTES - 2;
    localparam int CH_COUNT    = 16;
    localparam int CH_BITS     = 11;
    localparam int IDX_W       = $clog2(CH_COUNT);
    localparam int ACC_W       = CH_BITS + 8;
    localparam int CNT_W       = $clog2(ACC_W + 1);

    // marker bytes
    localparam logic [7:0] SYNC_BYTE = 8'h0F;
    localparam logic [7:0] TAIL_BYTE = 8'h00;

    // result kinds
    localparam logic KIND_CH = 1'b0;
    localparam logic KIND_ST = 1'b1;

    // hunt modes
    typedef enum logic [1:0] {
        MODE_WAIT  = 2'd0,
        MODE_SKIP  = 2'd1,
        MODE_FRAME = 2'd2
    } t_mode;

    // controller to datapath
    typedef struct packed {
        logic take;       // input ready, absorb the word on accept
        logic rd;         // read store at pointer, advance pointer
        logic absorb_rs;  // absorb the store read data (rescan)
        logic acc_load;   // append the store read data to the bit accumulator
        logic emit_ch;    // load a channel result into the output register
        logic emit_st;    // load a buffer-end status result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_valid;   // input word offered
        logic complete;   // offered word completes a frame
        logic good;       // completed frame has a valid tail
        logic hib;        // a header was taken in this buffer
        logic buf_end;    // accepted word ended the buffer
        logic ptr_end;    // pointer is past the last stored byte
        logic cnt_ok;     // accumulator will hold a whole channel after load
        logic last_ch;    // current channel is the last one
        logic out_free;   // output register can take a result
    } t_status;

endpackage

`default_nettype wire

// ----- hdl/sfrd_if.sv -----
// sfrd_if: valid/ready channel interfaces for input bytes and results
// depends on nothing
`default_nettype none

interface sfrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface sfrd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        digital_a;
    logic        digital_b;
    logic        frame_lost;
    logic        failsafe;
    logic        had_desync;
    logic        last;

    modport source (
        output valid, output kind, output channel_index, output channel_value,
        output digital_a, output digital_b, output frame_lost, output failsafe,
        output had_desync, output last, input ready
    );
    modport sink (
        input valid, input kind, input channel_index, input channel_value,
        input digital_a, input digital_b, input frame_lost, input failsafe,
        input had_desync, input last, output ready
    );
endinterface

`default_nettype wire

// ----- hdl/sfrd_ram.sv -----
// sfrd_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module sfrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sfrd_ctrl.sv -----
// sfrd_ctrl: sequencing state machine for byte intake, rescan,
// channel unpacking and status; depends on sfrd_pkg
`default_nettype none

module sfrd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sfrd_pkg::t_status i_status,
    output sfrd_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_END,
        S_RS_FIRST,
        S_RS_RUN,
        S_CH_FIRST,
        S_CH_LOAD,
        S_CH_EMIT,
        S_STATUS
    } t_state;

    t_state         r_state;
    t_state         n_state;
    sfrd_pkg::t_cmd n_cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                n_cmd.take = 1'b1;
                if (i_status.in_valid) begin
                    if (i_status.complete && i_status.good) begin
                        n_state = S_CH_FIRST;
                    end else if (i_status.complete && i_status.hib) begin
                        n_state = S_RS_FIRST;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_END: begin
                n_state = i_status.buf_end ? S_STATUS : S_IDLE;
            end
            S_RS_FIRST: begin
                n_cmd.rd = 1'b1;
                n_state  = S_RS_RUN;
            end
            S_RS_RUN: begin
                n_cmd.absorb_rs = 1'b1;
                if (i_status.ptr_end) begin
                    n_state = S_END;
                end else begin
                    n_cmd.rd = 1'b1;
                end
            end
            S_CH_FIRST: begin
                n_cmd.rd = 1'b1;
                n_state  = S_CH_LOAD;
            end
            S_CH_LOAD: begin
                n_cmd.acc_load = 1'b1;
                if (i_status.cnt_ok) begin
                    n_state = S_CH_EMIT;
                end else begin
                    n_cmd.rd = 1'b1;
                end
            end
            S_CH_EMIT: begin
                if (i_status.out_free) begin
                    n_cmd.emit_ch = 1'b1;
                    if (i_status.last_ch) begin
                        n_state = S_END;
                    end else begin
                        n_cmd.rd = 1'b1;
                        n_state  = S_CH_LOAD;
                    end
                end
            end
            S_STATUS: begin
                if (i_status.out_free) begin
                    n_cmd.emit_st = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = n_cmd;

endmodule

`default_nettype wire

// ----- hdl/sfrd_dp.sv -----
// sfrd_dp: hunt state, frame store, channel bit accumulator and output register
// depends on sfrd_pkg, sfrd_if and sfrd_ram
`default_nettype none

module sfrd_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfrd_pkg::t_cmd    i_cmd,
    output sfrd_pkg::t_status      o_status,
    sfrd_in_if.sink                i_in,
    sfrd_out_if.source             o_out
);

    // hunt state
    sfrd_pkg::t_mode               r_mode;
    sfrd_pkg::t_mode               n_mode;
    logic [sfrd_pkg::ADDR_W-1:0]   r_fill;
    logic [sfrd_pkg::ADDR_W-1:0]   n_fill;
    logic                          r_hib;
    logic                          n_hib;
    logic                          r_desync;
    logic                          n_desync;
    logic                          r_end;
    logic [3:0]                    r_flags;

    // store access and unpacking
    logic [sfrd_pkg::ADDR_W:0]     r_ptr;
    logic [sfrd_pkg::ACC_W-1:0]    r_acc;
    logic [sfrd_pkg::CNT_W-1:0]    r_cnt;
    logic [sfrd_pkg::IDX_W-1:0]    r_ch;
    logic [7:0]                    rd_data;

    // output register
    logic                          r_out_valid;
    logic                          r_kind;
    logic [sfrd_pkg::IDX_W-1:0]    r_idx;
    logic [sfrd_pkg::CH_BITS-1:0]  r_val;
    logic [3:0]                    r_out_flags;
    logic                          r_had;
    logic                          r_last;

    logic                          accept;
    logic                          ab_en;
    logic [7:0]                    ab_byte;
    logic                          ab_we;
    logic [sfrd_pkg::ADDR_W-1:0]   ab_waddr;
    logic                          ab_complete;
    logic                          good;
    logic                          out_free;

    assign accept  = i_cmd.take && i_in.valid;
    assign ab_en   = accept || i_cmd.absorb_rs;
    assign ab_byte = i_cmd.absorb_rs ? rd_data : i_in.data_byte;
    // header byte is always 0x0F by construction, so only the tail needs a check
    assign good    = (i_in.data_byte == sfrd_pkg::TAIL_BYTE);
    assign out_free = !r_out_valid || o_out.ready;

    // the byte taken in collecting mode at the last position finishes the frame
    assign ab_complete = (r_mode == sfrd_pkg::MODE_FRAME) &&
                         (r_fill == sfrd_pkg::ADDR_W'(sfrd_pkg::FRAME_BYTES - 1));

    // hunt logic for one byte
    always_comb begin
        n_mode      = r_mode;
        n_fill      = r_fill;
        n_hib       = r_hib;
        n_desync    = r_desync;
        ab_we       = 1'b0;
        ab_waddr    = r_fill;
        case (r_mode)
            sfrd_pkg::MODE_FRAME: begin
                ab_we       = 1'b1;
                n_fill      = r_fill + 1'b1;
            end
            sfrd_pkg::MODE_SKIP: begin
                if (ab_byte == sfrd_pkg::SYNC_BYTE) begin
                    n_mode = sfrd_pkg::MODE_WAIT;
                end
            end
            default: begin
                if (ab_byte == sfrd_pkg::SYNC_BYTE) begin
                    ab_we    = 1'b1;
                    ab_waddr = '0;
                    n_fill   = sfrd_pkg::ADDR_W'(1);
                    n_hib    = 1'b1;
                    n_mode   = sfrd_pkg::MODE_FRAME;
                end
            end
        endcase
        // frame completion decision
        if (ab_complete) begin
            n_fill = '0;
            if (good) begin
                n_desync = 1'b0;
                n_mode   = sfrd_pkg::MODE_WAIT;
            end else if (r_hib) begin
                n_mode   = sfrd_pkg::MODE_WAIT;
            end else begin
                n_desync = 1'b1;
                n_mode   = sfrd_pkg::MODE_SKIP;
            end
        end
    end

    // frame store
    sfrd_ram #(
        .WIDTH (8),
        .DEPTH (sfrd_pkg::FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ab_en && ab_we),
        .i_waddr (ab_waddr),
        .i_wdata (ab_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_ptr[sfrd_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    // hunt state registers; buffer-end status clears the per-buffer flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sfrd_pkg::MODE_WAIT;
            r_fill   <= '0;
            r_hib    <= 1'b0;
            r_desync <= 1'b0;
            r_end    <= 1'b0;
        end else begin
            if (ab_en) begin
                r_mode   <= n_mode;
                r_fill   <= n_fill;
                r_hib    <= n_hib;
                r_desync <= n_desync;
            end else if (i_cmd.emit_st) begin
                r_hib    <= 1'b0;
                r_desync <= 1'b0;
            end
            if (accept) begin
                r_end <= i_in.buffer_end;
            end
        end
    end

    // flag byte copy, taken whenever its store slot is written
    always_ff @(posedge i_clk) begin
        if (ab_en && ab_we && ab_waddr == sfrd_pkg::ADDR_W'(sfrd_pkg::FLAG_POS)) begin
            r_flags <= ab_byte[3:0];
        end
    end

    // read pointer and channel bit accumulator
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ptr <= (sfrd_pkg::ADDR_W + 1)'(1);
            r_acc <= '0;
            r_cnt <= '0;
            r_ch  <= '0;
        end else begin
            if (i_cmd.rd) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.acc_load) begin
                r_acc <= r_acc | (sfrd_pkg::ACC_W'(rd_data) << r_cnt);
                r_cnt <= r_cnt + sfrd_pkg::CNT_W'(8);
            end else if (i_cmd.emit_ch) begin
                r_acc <= r_acc >> sfrd_pkg::CH_BITS;
                r_cnt <= r_cnt - sfrd_pkg::CNT_W'(sfrd_pkg::CH_BITS);
                r_ch  <= r_ch + 1'b1;
            end
        end
    end

    // output register, control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_ch || i_cmd.emit_st) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register, payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ch) begin
            r_kind      <= sfrd_pkg::KIND_CH;
            r_idx       <= r_ch;
            r_val       <= r_acc[sfrd_pkg::CH_BITS-1:0];
            r_out_flags <= r_flags;
            r_had       <= 1'b0;
            r_last      <= (r_ch == sfrd_pkg::IDX_W'(sfrd_pkg::CH_COUNT - 1)) && !r_end;
        end else if (i_cmd.emit_st) begin
            r_kind      <= sfrd_pkg::KIND_ST;
            r_idx       <= '0;
            r_val       <= '0;
            r_out_flags <= '0;
            r_had       <= r_desync;
            r_last      <= 1'b1;
        end
    end

    // ports
    assign i_in.ready          = i_cmd.take;
    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.channel_index = r_idx;
    assign o_out.channel_value = r_val;
    assign o_out.digital_a     = r_out_flags[0];
    assign o_out.digital_b     = r_out_flags[1];
    assign o_out.frame_lost    = r_out_flags[2];
    assign o_out.failsafe      = r_out_flags[3];
    assign o_out.had_desync    = r_had;
    assign o_out.last          = r_last;

    // status to the controller
    always_comb begin
        o_status          = '0;
        o_status.in_valid = i_in.valid;
        o_status.complete = ab_complete;
        o_status.good     = good;
        o_status.hib      = r_hib;
        o_status.buf_end  = r_end;
        o_status.ptr_end  = (r_ptr == (sfrd_pkg::ADDR_W + 1)'(sfrd_pkg::FRAME_BYTES));
        o_status.cnt_ok   = (r_cnt >= sfrd_pkg::CNT_W'(sfrd_pkg::CH_BITS - 8));
        o_status.last_ch  = (r_ch == sfrd_pkg::IDX_W'(sfrd_pkg::CH_COUNT - 1));
        o_status.out_free = out_free;
    end

    // collecting mode always has a fill position inside the frame
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == sfrd_pkg::MODE_FRAME |->
            (r_fill != '0 && r_fill <= sfrd_pkg::ADDR_W'(sfrd_pkg::FRAME_BYTES - 1)))
        else $error("fill position out of range while collecting");

    // a rescan never holds enough bytes to finish a frame
    a_rescan_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.absorb_rs |-> !ab_complete)
        else $error("frame completed during rescan");

    // results only go into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_ch || i_cmd.emit_st) |-> out_free)
        else $error("result overwrote a pending word");

    // the last channel uses up exactly the remaining bits
    a_last_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_ch && r_ch == sfrd_pkg::IDX_W'(sfrd_pkg::CH_COUNT - 1)) |->
            r_cnt == sfrd_pkg::CNT_W'(sfrd_pkg::CH_BITS))
        else $error("channel bit count misaligned at last channel");

    // the store pointer is reset on every accepted word
    a_ptr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_ptr == (sfrd_pkg::ADDR_W + 1)'(1))
        else $error("store pointer not restarted");

endmodule

`default_nettype wire

// ----- hdl/sbus_frame_resync_decoder.sv -----
// sbus_frame_resync_decoder: top level, joins controller and datapath
// depends on sfrd_pkg, sfrd_if, sfrd_ctrl, sfrd_dp
//
// channel   dir  payload                                           words
// i_in      in   data_byte[7:0], buffer_end                        1 per byte
// o_out     out  kind, channel_index[3:0], channel_value[10:0],    0..17 per byte
//                digital_a, digital_b, frame_lost, failsafe,
//                had_desync, last
//
// a byte not ending a frame takes S_END (S_STATUS at buffer end) before the next
// a good frame unpacks 16 channels from 22 store reads
// a failed frame with hib set rescans 24 stored bytes via the one store read port
// i_rst_n is synchronous; the store holds no reset and needs no clearing pass
// the output register frees the input side; a stalled o_out holds the unpacking
// and the status word
`default_nettype none

module sbus_frame_resync_decoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sfrd_in_if.sink    i_in,
    sfrd_out_if.source o_out
);

    sfrd_pkg::t_cmd    cmd;
    sfrd_pkg::t_status status;

    // sequencer
    sfrd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // store, hunt state and result path
    sfrd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
